### rtl/ipv6_extension_header_walker_assert.svh
// ----------------------------------------------------------------------------
// ipv6 extension header walker assertion macros
// concurrent property helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef IPV6_EXTENSION_HEADER_WALKER_ASSERT_SVH
`define IPV6_EXTENSION_HEADER_WALKER_ASSERT_SVH

// same-cycle implication
`define EHW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EHW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ipv6ehw_pkg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_pkg
// types, header codes and status codes of the ipv6 extension header walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv6ehw_pkg;

    localparam int PosBits = 17;
    localparam int OutBits = 17;
    localparam int DlBits  = ((PosBits > OutBits) ? PosBits : OutBits) + 2;

    localparam logic [PosBits-1:0] PosMax   = '1;
    localparam logic [PosBits-1:0] HdrStart = PosBits'(40);

    localparam logic [3:0] IpVersion = 4'd6;

    localparam logic [7:0] HtHopByHop = 8'd0;
    localparam logic [7:0] HtRouting  = 8'd43;
    localparam logic [7:0] HtFragment = 8'd44;
    localparam logic [7:0] HtEsp      = 8'd50;
    localparam logic [7:0] HtAuth     = 8'd51;
    localparam logic [7:0] HtDestOpt  = 8'd60;

    localparam logic [2:0] StOk         = 3'd0;
    localparam logic [2:0] StBadVersion = 3'd1;
    localparam logic [2:0] StEsp        = 3'd2;
    localparam logic [2:0] StTruncated  = 3'd3;
    localparam logic [2:0] StMismatch   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         upper_protocol;
        logic [OutBits-1:0] data_offset;
        logic [OutBits-1:0] data_length;
        logic [15:0]        payload_length;
        logic [7:0]         hop_limit;
        logic [2:0]         status;
    } t_result;

    function automatic logic is_skip_header(input logic [7:0] t);
        return t inside {HtHopByHop, HtRouting, HtDestOpt, HtFragment, HtAuth};
    endfunction

endpackage

### rtl/ipv6ehw_in_reg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_in_reg
// input register stage holding one packet byte for the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv6ehw_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ipv6ehw_pkg::t_in_item i_item,
    input  logic                 i_take,
    output logic                 o_valid,
    output ipv6ehw_pkg::t_in_item o_item
);

    logic                  r_valid;
    logic                  n_valid;
    ipv6ehw_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/ipv6ehw_parser.sv
// ----------------------------------------------------------------------------
// ipv6ehw_parser
// per-byte header chain state and end-of-packet result computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv6ehw_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  ipv6ehw_pkg::t_in_item i_item,
    output ipv6ehw_pkg::t_result  o_result
);

    localparam int Pb = ipv6ehw_pkg::PosBits;
    localparam int Db = ipv6ehw_pkg::DlBits;
    localparam int Ob = ipv6ehw_pkg::OutBits;

    logic [Pb-1:0] r_pos,   n_pos;
    logic [7:0]    r_pend,  n_pend;
    logic [Pb-1:0] r_nhs,   n_nhs;
    logic          r_done,  n_done;
    logic [7:0]    r_fproto, n_fproto;
    logic [Pb-1:0] r_foff,  n_foff;
    logic [15:0]   r_pl,    n_pl;
    logic [7:0]    r_hop,   n_hop;
    logic [2:0]    r_err,   n_err;

    logic          counted;
    logic [7:0]    b;
    logic          ev_en;
    logic [7:0]    ev_type;
    logic [Pb-1:0] ev_start;
    logic [11:0]   skip;
    logic [Pb:0]   ns;

    logic [Pb-1:0] total;
    logic [Pb-1:0] remain;
    logic [Db-1:0] dl;
    logic          mismatch;

    // next state for one byte
    always_comb begin
        n_pos    = r_pos;
        n_pend   = r_pend;
        n_nhs    = r_nhs;
        n_done   = r_done;
        n_fproto = r_fproto;
        n_foff   = r_foff;
        n_pl     = r_pl;
        n_hop    = r_hop;
        n_err    = r_err;
        ev_en    = 1'b0;
        ev_type  = r_pend;
        ev_start = r_nhs;
        skip     = 12'd8;
        ns       = {1'b0, r_nhs};
        b        = i_item.data_byte;
        counted  = (r_pos != ipv6ehw_pkg::PosMax);

        if (counted) begin
            if (r_pos == Pb'(0) && b[7:4] != ipv6ehw_pkg::IpVersion &&
                r_err == ipv6ehw_pkg::StOk) begin
                n_err = ipv6ehw_pkg::StBadVersion;
            end
            if (r_pos == Pb'(4)) begin
                n_pl[15:8] = b;
            end
            if (r_pos == Pb'(5)) begin
                n_pl[7:0] = b;
            end
            if (r_pos == Pb'(6)) begin
                n_pend   = b;
                ev_en    = 1'b1;
                ev_type  = b;
                ev_start = r_nhs;
            end
            if (r_pos == Pb'(7)) begin
                n_hop = b;
            end
            if (!r_done && r_pos >= ipv6ehw_pkg::HdrStart) begin
                if (r_pos == r_nhs) begin
                    n_fproto = b;
                end else if ({1'b0, r_pos} == {1'b0, r_nhs} + (Pb+1)'(1)) begin
                    if (r_pend == ipv6ehw_pkg::HtFragment) begin
                        skip = 12'd8;
                    end else if (r_pend == ipv6ehw_pkg::HtAuth) begin
                        skip = 12'd8 + 12'({b, 2'b00});
                    end else begin
                        skip = 12'd8 + 12'({b, 3'b000});
                    end
                    ns = {1'b0, r_nhs} + (Pb+1)'(skip);
                    n_nhs = (ns > {1'b0, ipv6ehw_pkg::PosMax}) ?
                            ipv6ehw_pkg::PosMax : ns[Pb-1:0];
                    n_pend   = r_fproto;
                    ev_en    = 1'b1;
                    ev_type  = r_fproto;
                    ev_start = n_nhs;
                end
            end
            n_pos = r_pos + Pb'(1);
        end

        // header type decides whether the chain ends here
        if (ev_en && !ipv6ehw_pkg::is_skip_header(ev_type)) begin
            n_done = 1'b1;
            if (ev_type == ipv6ehw_pkg::HtEsp) begin
                if (n_err == ipv6ehw_pkg::StOk) begin
                    n_err = ipv6ehw_pkg::StEsp;
                end
            end else begin
                n_fproto = ev_type;
                n_foff   = ev_start;
            end
        end
    end

    // end-of-packet result
    always_comb begin
        total    = counted ? (r_pos + Pb'(1)) : r_pos;
        remain   = total - n_foff;
        dl       = Db'(40) + Db'(n_pl) - Db'(n_foff);
        mismatch = dl[Db-1] || (n_foff > total) || (dl > Db'(remain));

        o_result.payload_length = n_pl;
        o_result.hop_limit      = n_hop;
        o_result.upper_protocol = 8'd0;
        o_result.data_offset    = '0;
        o_result.data_length    = '0;
        if (n_err != ipv6ehw_pkg::StOk) begin
            o_result.status = n_err;
        end else if (!n_done) begin
            o_result.status = ipv6ehw_pkg::StTruncated;
        end else begin
            o_result.upper_protocol = n_fproto;
            o_result.data_offset    = Ob'(n_foff);
            if (mismatch) begin
                o_result.status = ipv6ehw_pkg::StMismatch;
            end else begin
                o_result.status      = ipv6ehw_pkg::StOk;
                o_result.data_length = Ob'(dl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_item.last_byte)) begin
            r_pos    <= '0;
            r_pend   <= 8'd0;
            r_nhs    <= ipv6ehw_pkg::HdrStart;
            r_done   <= 1'b0;
            r_fproto <= 8'd0;
            r_foff   <= ipv6ehw_pkg::HdrStart;
            r_pl     <= 16'd0;
            r_hop    <= 8'd0;
            r_err    <= ipv6ehw_pkg::StOk;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_pend   <= n_pend;
            r_nhs    <= n_nhs;
            r_done   <= n_done;
            r_fproto <= n_fproto;
            r_foff   <= n_foff;
            r_pl     <= n_pl;
            r_hop    <= n_hop;
            r_err    <= n_err;
        end
    end

endmodule

### rtl/ipv6ehw_out_reg.sv
// ----------------------------------------------------------------------------
// ipv6ehw_out_reg
// result register holding one packet summary until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv6ehw_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ipv6ehw_pkg::t_result i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_free,
    output ipv6ehw_pkg::t_result o_result
);

    logic                 r_valid;
    logic                 n_valid;
    ipv6ehw_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/ipv6_extension_header_walker.sv
// ----------------------------------------------------------------------------
// ipv6_extension_header_walker
// result: registered in the result register as its last byte is taken by the parser
// throughput: one byte per cycle; a last byte waits while an older result is held
// reset: synchronous active low, clears all chain state; next byte opens a packet
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv6_extension_header_walker_assert.svh"

module ipv6_extension_header_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_upper_protocol,
    output logic [16:0] o_data_offset,
    output logic [16:0] o_data_length,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_hop_limit,
    output logic [2:0]  o_status
);

    ipv6ehw_pkg::t_in_item in_item;
    ipv6ehw_pkg::t_in_item s1_item;
    ipv6ehw_pkg::t_result  res_next;
    ipv6ehw_pkg::t_result  res_out;
    logic                  s1_valid;
    logic                  out_free;
    logic                  adv;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    // a final byte waits for room in the result register
    assign adv = s1_valid && (!s1_item.last_byte || out_free);

    ipv6ehw_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    ipv6ehw_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (s1_item),
        .o_result (res_next)
    );

    ipv6ehw_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && s1_item.last_byte),
        .i_result (res_next),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (res_out)
    );

    assign o_upper_protocol = res_out.upper_protocol;
    assign o_data_offset    = res_out.data_offset;
    assign o_data_length    = res_out.data_length;
    assign o_payload_length = res_out.payload_length;
    assign o_hop_limit      = res_out.hop_limit;
    assign o_status         = res_out.status;

    `EHW_ASSERT_IMPL(a_err_fields_zero, i_clk, i_rst_n, o_out_valid && (o_status == ipv6ehw_pkg::StBadVersion || o_status == ipv6ehw_pkg::StEsp || o_status == ipv6ehw_pkg::StTruncated), o_upper_protocol == 8'd0 && o_data_offset == 17'd0 && o_data_length == 17'd0, "error result carries chain fields")
    `EHW_ASSERT_IMPL(a_mismatch_len_zero, i_clk, i_rst_n, o_out_valid && o_status == ipv6ehw_pkg::StMismatch, o_data_length == 17'd0, "mismatch result carries a length")
    `EHW_ASSERT_IMPL(a_ok_len_sum, i_clk, i_rst_n, o_out_valid && o_status == ipv6ehw_pkg::StOk, ({2'b00, o_payload_length} + 18'd40) == ({1'b0, o_data_offset} + {1'b0, o_data_length}), "offset plus length disagrees with payload length")
    `EHW_ASSERT_NEXT(a_final_byte_loads, i_clk, i_rst_n, adv && s1_item.last_byte, o_out_valid, "final byte transfer gave no result")

endmodule

### tb/sv/tb_ipv6_extension_header_walker.sv
// ----------------------------------------------------------------------------
// tb_ipv6_extension_header_walker
// streams ipv6 packets byte by byte through the walker, with directed corner
// packets and random chains, and checks every field of each packet report
// against an in-bench chain parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv6_extension_header_walker;

    localparam logic [7:0] UpTcp  = 8'd6;
    localparam logic [7:0] UpUdp  = 8'd17;
    localparam logic [7:0] UpNone = 8'd59;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_upper_protocol;
    logic [16:0] o_data_offset;
    logic [16:0] o_data_length;
    logic [15:0] o_payload_length;
    logic [7:0]  o_hop_limit;
    logic [2:0]  o_status;

    ipv6ehw_pkg::t_in_item wire_bytes[$];
    ipv6ehw_pkg::t_in_item next_byte;
    ipv6ehw_pkg::t_result  pending_reports[$];
    ipv6ehw_pkg::t_result  due_report;
    logic [7:0] chain_types[$];
    logic [7:0] chain_lens[$];

    // parser state
    logic [ipv6ehw_pkg::PosBits-1:0] walk_pos;
    logic [ipv6ehw_pkg::PosBits-1:0] walk_next;
    logic [ipv6ehw_pkg::PosBits-1:0] walk_off;
    logic [7:0]                      walk_pending;
    logic [7:0]                      walk_proto;
    logic [7:0]                      walk_hop;
    logic [15:0]                     walk_pl;
    logic                            walk_done;
    logic [2:0]                      walk_err;

    logic failed = 1'b0;
    logic byte_taken = 1'b0;
    logic held_once = 1'b0;
    int   bytes_taken = 0;
    int   burst_mark = 0;
    int   calm_lo = 0;
    int   calm_hi = 0;
    int   hold_left = 0;

    ipv6_extension_header_walker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_upper_protocol (o_upper_protocol),
        .o_data_offset    (o_data_offset),
        .o_data_length    (o_data_length),
        .o_payload_length (o_payload_length),
        .o_hop_limit      (o_hop_limit),
        .o_status         (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_ext_header(input logic [7:0] t);
        return t inside {ipv6ehw_pkg::HtHopByHop, ipv6ehw_pkg::HtRouting,
                         ipv6ehw_pkg::HtDestOpt, ipv6ehw_pkg::HtFragment,
                         ipv6ehw_pkg::HtAuth};
    endfunction

    function automatic int ext_span(input logic [7:0] t, input logic [7:0] len);
        case (t)
            ipv6ehw_pkg::HtFragment: return 8;
            ipv6ehw_pkg::HtAuth:     return 8 + 4 * int'(len);
            default:                 return 8 + 8 * int'(len);
        endcase
    endfunction

    function automatic void clear_walk();
        walk_pos     = '0;
        walk_next    = ipv6ehw_pkg::HdrStart;
        walk_off     = ipv6ehw_pkg::HdrStart;
        walk_pending = '0;
        walk_proto   = '0;
        walk_hop     = '0;
        walk_pl      = '0;
        walk_done    = 1'b0;
        walk_err     = ipv6ehw_pkg::StOk;
    endfunction

    function automatic void settle_chain();
        if (is_ext_header(walk_pending))
            return;
        walk_done = 1'b1;
        if (walk_pending == ipv6ehw_pkg::HtEsp) begin
            if (walk_err == ipv6ehw_pkg::StOk)
                walk_err = ipv6ehw_pkg::StEsp;
        end else begin
            walk_proto = walk_pending;
            walk_off   = walk_next;
        end
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int                   pos;
        int                   ns;
        int                   total;
        int                   dl;
        logic                 counted;
        ipv6ehw_pkg::t_result rep;
        pos = int'(walk_pos);
        counted = pos < int'(ipv6ehw_pkg::PosMax);
        if (counted) begin
            if (pos == 0 && b[7:4] != ipv6ehw_pkg::IpVersion &&
                walk_err == ipv6ehw_pkg::StOk)
                walk_err = ipv6ehw_pkg::StBadVersion;
            if (pos == 4)
                walk_pl[15:8] = b;
            if (pos == 5)
                walk_pl[7:0] = b;
            if (pos == 6) begin
                walk_pending = b;
                settle_chain();
            end
            if (pos == 7)
                walk_hop = b;
            if (!walk_done && pos >= 40) begin
                if (pos == int'(walk_next)) begin
                    walk_proto = b;
                end else if (pos == int'(walk_next) + 1) begin
                    ns = int'(walk_next) + ext_span(walk_pending, b);
                    walk_next = (ns > int'(ipv6ehw_pkg::PosMax)) ?
                                ipv6ehw_pkg::PosMax : ipv6ehw_pkg::PosBits'(ns);
                    walk_pending = walk_proto;
                    settle_chain();
                end
            end
            walk_pos = ipv6ehw_pkg::PosBits'(pos + 1);
        end
        if (!last)
            return;
        rep = '0;
        rep.payload_length = walk_pl;
        rep.hop_limit = walk_hop;
        total = counted ? pos + 1 : pos;
        if (walk_err != ipv6ehw_pkg::StOk) begin
            rep.status = walk_err;
        end else if (!walk_done) begin
            rep.status = ipv6ehw_pkg::StTruncated;
        end else begin
            dl = 40 + int'(walk_pl) - int'(walk_off);
            rep.upper_protocol = walk_proto;
            rep.data_offset = walk_off;
            if (dl < 0 || int'(walk_off) > total || dl > total - int'(walk_off)) begin
                rep.status = ipv6ehw_pkg::StMismatch;
            end else begin
                rep.status = ipv6ehw_pkg::StOk;
                rep.data_length = ipv6ehw_pkg::OutBits'(dl);
            end
        end
        pending_reports.push_back(rep);
        clear_walk();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        ipv6ehw_pkg::t_in_item item;
        item.data_byte = b;
        item.last_byte = last;
        wire_bytes.push_back(item);
    endtask

    task automatic add_hdr(input logic [7:0] t, input logic [7:0] len);
        chain_types.push_back(t);
        chain_lens.push_back(len);
    endtask

    // builds one packet from the queued chain, then empties the chain
    task automatic make_packet(input logic [3:0] ver, input logic [7:0] upper,
                               input int data_len, input int pl_adj, input int cut);
        logic [7:0]  pkt[$];
        logic [7:0]  first;
        logic [15:0] pl;
        int          total;
        repeat (40) pkt.push_back(8'($urandom));
        first = pkt[0];
        pkt[0] = {ver, first[3:0]};
        pkt[6] = (chain_types.size() > 0) ? chain_types[0] : upper;
        for (int i = 0; i < chain_types.size(); i++) begin
            pkt.push_back((i + 1 < chain_types.size()) ? chain_types[i + 1] : upper);
            pkt.push_back(chain_lens[i]);
            repeat (ext_span(chain_types[i], chain_lens[i]) - 2)
                pkt.push_back(8'($urandom));
        end
        repeat (data_len) pkt.push_back(8'($urandom));
        total = pkt.size();
        pl = 16'(total - 40 + pl_adj);
        pkt[4] = pl[15:8];
        pkt[5] = pl[7:0];
        if (cut > 0 && cut < total)
            total = cut;
        for (int i = 0; i < total; i++)
            push_byte(pkt[i], i == total - 1);
        chain_types.delete();
        chain_lens.delete();
    endtask

    // report check and byte transfer tracking
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report transfer with no packet outstanding");
                failed = 1'b1;
            end else begin
                due_report = pending_reports.pop_front();
                check_field("upper_protocol", int'(due_report.upper_protocol),
                            int'(o_upper_protocol));
                check_field("data_offset", int'(due_report.data_offset),
                            int'(o_data_offset));
                check_field("data_length", int'(due_report.data_length),
                            int'(o_data_length));
                check_field("payload_length", int'(due_report.payload_length),
                            int'(o_payload_length));
                check_field("hop_limit", int'(due_report.hop_limit), int'(o_hop_limit));
                check_field("status", int'(due_report.status), int'(o_status));
            end
        end
        if (byte_taken) begin
            parse_byte(i_data_byte, i_last_byte);
            bytes_taken++;
        end
    end

    // byte sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            if (wire_bytes.size() > 0 &&
                ((bytes_taken >= calm_lo && bytes_taken < calm_hi) ||
                 $urandom_range(0, 99) >= 27)) begin
                next_byte = wire_bytes.pop_front();
                i_in_valid  <= 1'b1;
                i_data_byte <= next_byte.data_byte;
                i_last_byte <= next_byte.last_byte;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // report receiver, with one long hold-off during the one-byte burst
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!held_once && burst_mark > 0 && bytes_taken > burst_mark) begin
            held_once = 1'b1;
            hold_left = 300;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (bytes_taken >= calm_lo && bytes_taken < calm_hi) ||
                           $urandom_range(0, 99) >= 27;
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int         kind;
        int         pkts;
        int         cnt;
        logic [7:0] hdr;
        logic [7:0] len;
        logic [7:0] upper;
        logic [3:0] ver;

        clear_walk();

        // bare fixed header, tcp right after it
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 0, 0, 0);
        // every extension kind in one chain
        add_hdr(ipv6ehw_pkg::HtHopByHop, 8'd0);
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd1);
        add_hdr(ipv6ehw_pkg::HtDestOpt, 8'd2);
        add_hdr(ipv6ehw_pkg::HtFragment, 8'd255);
        add_hdr(ipv6ehw_pkg::HtAuth, 8'd3);
        make_packet(ipv6ehw_pkg::IpVersion, UpUdp, 20, 0, 0);
        // largest ah header, upper value at the top of the range
        add_hdr(ipv6ehw_pkg::HtAuth, 8'd255);
        make_packet(ipv6ehw_pkg::IpVersion, 8'd255, 0, 0, 0);
        // esp right after the fixed header and after a fragment header
        make_packet(ipv6ehw_pkg::IpVersion, ipv6ehw_pkg::HtEsp, 8, 0, 0);
        add_hdr(ipv6ehw_pkg::HtFragment, 8'd0);
        make_packet(ipv6ehw_pkg::IpVersion, ipv6ehw_pkg::HtEsp, 8, 0, 0);
        // bad version, alone and ahead of esp
        make_packet(4'd4, UpTcp, 4, 0, 0);
        make_packet(4'd15, ipv6ehw_pkg::HtEsp, 0, 0, 0);
        // one-byte packets back to back
        burst_mark = wire_bytes.size();
        repeat (20) make_packet(4'($urandom), UpTcp, 0, 0, 1);
        // cut before the next header byte and before the hop limit
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 0, 0, 6);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 0, 0, 7);
        // cut before, on the type byte of, on the length byte of, inside a header
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd1);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 8, 0, 40);
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd1);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 8, 0, 41);
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd1);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 8, 0, 42);
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd1);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 8, 0, 50);
        // payload length against packet size
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 10, 1, 0);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 10, -5, 0);
        add_hdr(ipv6ehw_pkg::HtRouting, 8'd3);
        make_packet(ipv6ehw_pkg::IpVersion, UpTcp, 4, -36, 0);
        make_packet(ipv6ehw_pkg::IpVersion, UpNone, 0, 65535, 0);

        calm_lo = 300;
        calm_hi = 900;
        pkts = 0;
        while (wire_bytes.size() < 1900 || pkts < 4) begin
            kind = $urandom_range(0, 99);
            pkts++;
            if (kind < 85) begin
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 4))
                        0: hdr = ipv6ehw_pkg::HtHopByHop;
                        1: hdr = ipv6ehw_pkg::HtRouting;
                        2: hdr = ipv6ehw_pkg::HtDestOpt;
                        3: hdr = ipv6ehw_pkg::HtFragment;
                        default: hdr = ipv6ehw_pkg::HtAuth;
                    endcase
                    len = ($urandom_range(0, 199) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 3));
                    add_hdr(hdr, len);
                end
                upper = 8'($urandom);
                while (is_ext_header(upper))
                    upper = 8'($urandom);
                if ($urandom_range(0, 19) == 0)
                    upper = ipv6ehw_pkg::HtEsp;
                ver = ($urandom_range(0, 29) == 0) ? 4'($urandom) : ipv6ehw_pkg::IpVersion;
                make_packet(ver, upper, int'($urandom_range(0, 24)),
                            ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8)) - 4 : 0,
                            (kind >= 70) ? int'($urandom_range(1, 80)) : 0);
            end else begin
                cnt = int'($urandom_range(1, 60));
                for (int i = 0; i < cnt; i++)
                    push_byte(8'($urandom), i == cnt - 1);
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (wire_bytes.size() > 0 || i_in_valid || pending_reports.size() > 0)
            @(posedge i_clk);
        repeat (20) @(negedge i_clk);
        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ipv6ehw_pkg.sv
rtl/ipv6ehw_in_reg.sv
rtl/ipv6ehw_parser.sv
rtl/ipv6ehw_out_reg.sv
rtl/ipv6_extension_header_walker.sv
tb/sv/tb_ipv6_extension_header_walker.sv
